/* hdl/assert_macros.svh */
// assertion macros shared by the frame receiver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SFR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SFR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hdl/sfr_pkg.sv */
// types and constants of the serial frame receiver
`default_nettype none

package sfr_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = 5;
    localparam int NBANK       = 2;
    localparam int BANK_W      = $clog2(NBANK);
    localparam int ADDR_W      = BANK_W + IDX_W;
    localparam int MEM_DEPTH   = NBANK * MAX_PAYLOAD;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] HDR1 = 8'hfe;
    localparam logic [7:0] HDR2 = 8'h68;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_CSUM = 2'd1,
        ST_LEN  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HDR1 = 3'd1,
        PH_SRC  = 3'd2,
        PH_DST  = 3'd3,
        PH_CMD  = 3'd4,
        PH_LEN  = 3'd5,
        PH_DATA = 3'd6,
        PH_SUM  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_SHOW = 2'd2
    } t_back_state;

    typedef struct packed {
        t_status           status;
        logic [7:0]        src;
        logic [7:0]        dst;
        logic [7:0]        cmd;
        logic [LEN_W-1:0]  len;
        logic [BANK_W-1:0] bank;
    } t_job;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    typedef struct packed {
        logic              en;
        logic [BANK_W-1:0] bank;
    } t_done;

endpackage

`default_nettype wire

/* hdl/sfr_if.sv */
// byte and result channel interfaces of the serial frame receiver
`default_nettype none

interface sfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] src_addr;
    logic [7:0] dst_addr;
    logic [7:0] command;
    logic [4:0] payload_len;
    logic [3:0] byte_index;
    logic [7:0] payload_byte;
    logic       last;

    modport source (
        output valid, output status, output src_addr, output dst_addr, output command,
        output payload_len, output byte_index, output payload_byte, output last,
        input ready
    );
    modport sink (
        input valid, input status, input src_addr, input dst_addr, input command,
        input payload_len, input byte_index, input payload_byte, input last,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/sfr_front.sv */
// header hunt, field capture, checksum and payload write of the receiver
`default_nettype none
`include "assert_macros.svh"

module sfr_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    sfr_rx_if.sink           i_rx,
    output logic             o_push,
    output sfr_pkg::t_job    o_job,
    input  wire              i_full,
    output sfr_pkg::t_wr     o_wr,
    input  sfr_pkg::t_done   i_done
);

    localparam logic [sfr_pkg::BANK_W-1:0] BANK_W_ONE = sfr_pkg::BANK_W'(1);
    localparam logic [sfr_pkg::NBANK-1:0]  BUSY_ONE   = sfr_pkg::NBANK'(1);

    sfr_pkg::t_phase                  r_phase, n_phase;
    logic [7:0]                       r_src, r_dst, r_cmd, r_len, r_sum;
    logic [sfr_pkg::LEN_W-1:0]        r_cnt;
    logic [sfr_pkg::BANK_W-1:0]       r_bank;
    logic [sfr_pkg::NBANK-1:0]        r_busy;

    logic                             accept;
    logic [7:0]                       c;
    logic [sfr_pkg::LEN_W-1:0]        cnt_inc;
    logic                             too_long;
    logic                             csum_bad;
    logic [7:0]                       sum_chk;
    logic                             take_bank;
    logic [sfr_pkg::NBANK-1:0]        busy_set;
    logic [sfr_pkg::NBANK-1:0]        busy_clr;

    assign c        = i_rx.rx_byte;
    assign i_rx.ready = !i_full && !(r_phase == sfr_pkg::PH_DATA && r_busy[r_bank]);
    assign accept   = i_rx.valid && i_rx.ready;
    assign cnt_inc  = r_cnt + sfr_pkg::LEN_W'(1);
    assign too_long = c > 8'(sfr_pkg::MAX_PAYLOAD);
    assign sum_chk  = r_sum + c;
    assign csum_bad = sum_chk != 8'd0;

    // bank ownership passes to the back end for a good frame with payload
    assign take_bank = o_push && o_job.status == sfr_pkg::ST_OK && o_job.len != '0;
    assign busy_set  = take_bank ? (BUSY_ONE << r_bank) : '0;
    assign busy_clr  = i_done.en ? (BUSY_ONE << i_done.bank) : '0;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                sfr_pkg::PH_IDLE: begin
                    if (c == sfr_pkg::HDR1) n_phase = sfr_pkg::PH_HDR1;
                end
                sfr_pkg::PH_HDR1: begin
                    if (c == sfr_pkg::HDR2) n_phase = sfr_pkg::PH_SRC;
                    else if (c != sfr_pkg::HDR1) n_phase = sfr_pkg::PH_IDLE;
                end
                sfr_pkg::PH_SRC: n_phase = sfr_pkg::PH_DST;
                sfr_pkg::PH_DST: n_phase = sfr_pkg::PH_CMD;
                sfr_pkg::PH_CMD: n_phase = sfr_pkg::PH_LEN;
                sfr_pkg::PH_LEN: begin
                    if (too_long) n_phase = sfr_pkg::PH_IDLE;
                    else if (c == 8'd0) n_phase = sfr_pkg::PH_SUM;
                    else n_phase = sfr_pkg::PH_DATA;
                end
                sfr_pkg::PH_DATA: begin
                    if ({3'd0, cnt_inc} >= r_len) n_phase = sfr_pkg::PH_SUM;
                end
                sfr_pkg::PH_SUM: n_phase = sfr_pkg::PH_IDLE;
                default: n_phase = sfr_pkg::PH_IDLE;
            endcase
        end
    end

    // job and payload write
    always_comb begin
        o_push     = accept && ((r_phase == sfr_pkg::PH_LEN && too_long)
                                || r_phase == sfr_pkg::PH_SUM);
        o_job.src  = r_src;
        o_job.dst  = r_dst;
        o_job.cmd  = r_cmd;
        o_job.bank = r_bank;
        if (r_phase == sfr_pkg::PH_LEN) begin
            o_job.status = sfr_pkg::ST_LEN;
            o_job.len    = '0;
        end else begin
            o_job.status = csum_bad ? sfr_pkg::ST_CSUM : sfr_pkg::ST_OK;
            o_job.len    = r_len[sfr_pkg::LEN_W-1:0];
        end
        o_wr.en   = accept && r_phase == sfr_pkg::PH_DATA;
        o_wr.addr = {r_bank, r_cnt[sfr_pkg::IDX_W-1:0]};
        o_wr.data = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfr_pkg::PH_IDLE;
            r_bank  <= '0;
            r_busy  <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_cmd   <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            if (accept) begin
                unique case (r_phase)
                    sfr_pkg::PH_HDR1: begin
                        if (c == sfr_pkg::HDR2) r_sum <= sfr_pkg::HDR1 + sfr_pkg::HDR2;
                    end
                    sfr_pkg::PH_SRC: begin
                        r_src <= c;
                        r_sum <= sum_chk;
                    end
                    sfr_pkg::PH_DST: begin
                        r_dst <= c;
                        r_sum <= sum_chk;
                    end
                    sfr_pkg::PH_CMD: begin
                        r_cmd <= c;
                        r_sum <= sum_chk;
                    end
                    sfr_pkg::PH_LEN: begin
                        r_len <= c;
                        r_sum <= sum_chk;
                        r_cnt <= '0;
                    end
                    sfr_pkg::PH_DATA: begin
                        r_sum <= sum_chk;
                        r_cnt <= cnt_inc;
                    end
                    default: begin
                    end
                endcase
            end
            if (take_bank) r_bank <= r_bank + BANK_W_ONE;
            r_busy <= (r_busy | busy_set) & ~busy_clr;
        end
    end

    `SFR_ASSERT_IMP(a_wr_free_bank, i_clk, i_rst_n, o_wr.en, !r_busy[r_bank])
    `SFR_ASSERT_IMP(a_done_busy, i_clk, i_rst_n, i_done.en, r_busy[i_done.bank])

endmodule

`default_nettype wire

/* hdl/sfr_fifo.sv */
// short job queue between front and back end
`default_nettype none
`include "assert_macros.svh"

module sfr_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  sfr_pkg::t_job   i_job,
    output logic            o_full,
    output logic            o_valid,
    input  wire             i_pop,
    output sfr_pkg::t_job   o_job
);

    sfr_pkg::t_job                r_slot [sfr_pkg::FIFO_DEPTH];
    logic [sfr_pkg::FIFO_AW-1:0]  r_wp, r_rp;
    logic [sfr_pkg::FIFO_CW-1:0]  r_cnt;

    assign o_full  = r_cnt == sfr_pkg::FIFO_CW'(sfr_pkg::FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + sfr_pkg::FIFO_AW'(1);
            if (i_pop) r_rp <= r_rp + sfr_pkg::FIFO_AW'(1);
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + sfr_pkg::FIFO_CW'(1);
                2'b01:   r_cnt <= r_cnt - sfr_pkg::FIFO_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `SFR_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `SFR_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid)

endmodule

`default_nettype wire

/* hdl/sfr_back.sv */
// payload buffer and result sequencer of the receiver
`default_nettype none
`include "assert_macros.svh"

module sfr_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_pop,
    input  sfr_pkg::t_job    i_job,
    input  sfr_pkg::t_wr     i_wr,
    output sfr_pkg::t_done   o_done,
    sfr_res_if.source        o_res
);

    logic [7:0]                 r_mem [sfr_pkg::MEM_DEPTH];
    sfr_pkg::t_back_state       r_state, n_state;
    sfr_pkg::t_job              r_job;
    logic [sfr_pkg::IDX_W-1:0]  r_idx;
    logic [7:0]                 r_rd;

    logic                       payload_mode;
    logic                       job_payload;
    logic [sfr_pkg::LEN_W-1:0]  idx_inc;
    logic                       is_last;

    assign payload_mode = r_job.status == sfr_pkg::ST_OK && r_job.len != '0;
    assign job_payload  = i_job.status == sfr_pkg::ST_OK && i_job.len != '0;
    assign idx_inc      = {1'b0, r_idx} + sfr_pkg::LEN_W'(1);
    assign is_last      = !payload_mode || idx_inc == r_job.len;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfr_pkg::BK_IDLE: begin
                if (i_valid) n_state = job_payload ? sfr_pkg::BK_READ : sfr_pkg::BK_SHOW;
            end
            sfr_pkg::BK_READ: n_state = sfr_pkg::BK_SHOW;
            sfr_pkg::BK_SHOW: begin
                if (o_res.ready) n_state = is_last ? sfr_pkg::BK_IDLE : sfr_pkg::BK_READ;
            end
            default: n_state = sfr_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop              = r_state == sfr_pkg::BK_IDLE && i_valid;
        o_res.valid        = r_state == sfr_pkg::BK_SHOW;
        o_res.status       = r_job.status;
        o_res.src_addr     = r_job.src;
        o_res.dst_addr     = r_job.dst;
        o_res.command      = r_job.cmd;
        o_res.payload_len  = r_job.len;
        o_res.byte_index   = r_idx;
        o_res.payload_byte = payload_mode ? r_rd : 8'd0;
        o_res.last         = is_last;
        o_done.en          = o_res.valid && o_res.ready && is_last && payload_mode;
        o_done.bank        = r_job.bank;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[i_wr.addr] <= i_wr.data;
        if (r_state == sfr_pkg::BK_READ) r_rd <= r_mem[{r_job.bank, r_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfr_pkg::BK_IDLE;
            r_idx   <= '0;
            r_job   <= '0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_job <= i_job;
                r_idx <= '0;
            end else if (o_res.valid && o_res.ready && !is_last) begin
                r_idx <= r_idx + sfr_pkg::IDX_W'(1);
            end
        end
    end

    `SFR_ASSERT_IMP(a_err_single, i_clk, i_rst_n,
        o_res.valid && r_job.status != sfr_pkg::ST_OK, o_res.last && r_idx == '0)
    `SFR_ASSERT_IMP(a_idx_in_len, i_clk, i_rst_n,
        o_res.valid && payload_mode, {1'b0, r_idx} < r_job.len)
    `SFR_ASSERT_NXT(a_last_ends, i_clk, i_rst_n,
        o_res.valid && o_res.ready && o_res.last, r_state == sfr_pkg::BK_IDLE)

endmodule

`default_nettype wire

/* hdl/serial_frame_receiver.sv */
// top level of the serial frame receiver
// Usage:
//   i_rx carries one received serial byte per beat (rx_byte). The block hunts
//   for the header fe 68, captures src, dst, command, length, payload and the
//   checksum byte, and checks that all bytes sum to zero mod 256.
//   o_res carries result beats: one per payload byte of a good frame (last on
//   the final one), or one beat for an empty payload, a checksum error
//   (status 1) or a length above 16 (status 2).
// Timing:
//   a byte is taken whenever the parser is not held back. A frame's job is
//   queued on its checksum byte (or bad length byte); once it is popped, an
//   error or empty-payload result is shown directly, and each payload result
//   is shown after its own registered read of the payload buffer.
//   A two-entry job queue and a two-bank payload buffer let the parser take
//   the next frame while the previous one is still being delivered.
// Stalls and reset:
//   when o_res is stalled the parser keeps accepting until the job queue is
//   full, or until it needs a payload bank still being delivered.
//   Reset returns the parser to header hunting and empties the queue.
`default_nettype none

module serial_frame_receiver (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sfr_rx_if.sink     i_rx,
    sfr_res_if.source  o_res
);

    logic             push, full, q_valid, pop;
    sfr_pkg::t_job    push_job, q_job;
    sfr_pkg::t_wr     wr;
    sfr_pkg::t_done   done;

    sfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full),
        .o_wr    (wr),
        .i_done  (done)
    );

    sfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (q_job)
    );

    sfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (pop),
        .i_job   (q_job),
        .i_wr    (wr),
        .o_done  (done),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

/* test/testbench.sv */
// serial frame receiver testbench: byte stream in, deframed beats checked against a predictor
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 170;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 20;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        sfr_pkg::t_status status;
        logic [7:0]       src;
        logic [7:0]       dst;
        logic [7:0]       cmd;
        logic [4:0]       len;
        logic [3:0]       idx;
        logic [7:0]       data;
        logic             last;
    } t_beat;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        t_beat      want;
    } t_stim;

    localparam t_beat NO_BEAT = '0;

    localparam t_stim DIRECTED [26] = '{
        // noise while idle, broken header
        {8'h00, 1'b0, NO_BEAT},
        {8'hfe, 1'b0, NO_BEAT},
        {8'h55, 1'b0, NO_BEAT},
        // repeated first header byte, header bytes as fields, empty payload
        {8'hfe, 1'b0, NO_BEAT},
        {8'hfe, 1'b0, NO_BEAT},
        {8'h68, 1'b0, NO_BEAT},
        {8'hfe, 1'b0, NO_BEAT},
        {8'h68, 1'b0, NO_BEAT},
        {8'hff, 1'b0, NO_BEAT},
        {8'h00, 1'b0, NO_BEAT},
        {8'h35, 1'b1, sfr_pkg::ST_OK, 8'hfe, 8'h68, 8'hff, 5'd0, 4'd0, 8'h00, 1'b1},
        // length one above the buffer size
        {8'hfe, 1'b0, NO_BEAT},
        {8'h68, 1'b0, NO_BEAT},
        {8'h00, 1'b0, NO_BEAT},
        {8'h00, 1'b0, NO_BEAT},
        {8'h00, 1'b0, NO_BEAT},
        {8'h11, 1'b1, sfr_pkg::ST_LEN, 8'h00, 8'h00, 8'h00, 5'd0, 4'd0, 8'h00, 1'b1},
        // bad checksum equal to the first header byte, then a stray second header byte
        {8'hfe, 1'b0, NO_BEAT},
        {8'h68, 1'b0, NO_BEAT},
        {8'hff, 1'b0, NO_BEAT},
        {8'hff, 1'b0, NO_BEAT},
        {8'h00, 1'b0, NO_BEAT},
        {8'h01, 1'b0, NO_BEAT},
        {8'hff, 1'b0, NO_BEAT},
        {8'hfe, 1'b1, sfr_pkg::ST_CSUM, 8'hff, 8'hff, 8'h00, 5'd1, 4'd0, 8'h00, 1'b1},
        {8'h68, 1'b0, NO_BEAT}
    };

    logic i_clk;
    logic i_rst_n;

    sfr_rx_if  rx ();
    sfr_res_if res ();

    serial_frame_receiver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx),
        .o_res   (res)
    );

    sfr_pkg::t_phase hunt_phase = sfr_pkg::PH_IDLE;
    logic [7:0]      cap_src    = '0;
    logic [7:0]      cap_dst    = '0;
    logic [7:0]      cap_cmd    = '0;
    logic [7:0]      cap_len    = '0;
    logic [7:0]      acc        = '0;
    int unsigned     fill       = 0;
    logic [7:0]      store [sfr_pkg::MAX_PAYLOAD];

    t_beat due_beats [$];
    t_beat seen_beat;
    t_beat due_beat;

    int mismatches  = 0;
    int items_taken = 0;
    int idle_cycles = 0;
    int tx_calm     = 0;
    int rx_calm     = 0;
    int sink_hold   = 0;

    function automatic int pick_pause(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] field_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return sfr_pkg::HDR1;
        if (r < 20) return sfr_pkg::HDR2;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic string beat_str(t_beat b);
        return $sformatf("status=%0d src=%02h dst=%02h cmd=%02h len=%0d idx=%0d byte=%02h last=%0b",
            b.status, b.src, b.dst, b.cmd, b.len, b.idx, b.data, b.last);
    endfunction

    function void queue_beat(sfr_pkg::t_status st, logic [4:0] len, logic [3:0] idx,
                             logic [7:0] val, logic fin);
        due_beats.push_back({st, cap_src, cap_dst, cap_cmd, len, idx, val, fin});
    endfunction

    function void deframe(logic [7:0] b);
        logic [7:0] total;
        case (hunt_phase)
            sfr_pkg::PH_IDLE: begin
                if (b == sfr_pkg::HDR1) hunt_phase = sfr_pkg::PH_HDR1;
            end
            sfr_pkg::PH_HDR1: begin
                if (b == sfr_pkg::HDR2) begin
                    hunt_phase = sfr_pkg::PH_SRC;
                    acc = sfr_pkg::HDR1 + sfr_pkg::HDR2;
                end else if (b != sfr_pkg::HDR1) begin
                    hunt_phase = sfr_pkg::PH_IDLE;
                end
            end
            sfr_pkg::PH_SRC: begin
                cap_src = b;
                acc += b;
                hunt_phase = sfr_pkg::PH_DST;
            end
            sfr_pkg::PH_DST: begin
                cap_dst = b;
                acc += b;
                hunt_phase = sfr_pkg::PH_CMD;
            end
            sfr_pkg::PH_CMD: begin
                cap_cmd = b;
                acc += b;
                hunt_phase = sfr_pkg::PH_LEN;
            end
            sfr_pkg::PH_LEN: begin
                cap_len = b;
                acc += b;
                fill = 0;
                if (b > sfr_pkg::MAX_PAYLOAD) begin
                    hunt_phase = sfr_pkg::PH_IDLE;
                    queue_beat(sfr_pkg::ST_LEN, 5'd0, 4'd0, 8'h00, 1'b1);
                end else if (b == 8'h00) begin
                    hunt_phase = sfr_pkg::PH_SUM;
                end else begin
                    hunt_phase = sfr_pkg::PH_DATA;
                end
            end
            sfr_pkg::PH_DATA: begin
                if (fill < sfr_pkg::MAX_PAYLOAD) store[fill] = b;
                acc += b;
                fill++;
                if (fill >= cap_len) hunt_phase = sfr_pkg::PH_SUM;
            end
            sfr_pkg::PH_SUM: begin
                total = acc + b;
                hunt_phase = sfr_pkg::PH_IDLE;
                if (total != 8'h00) begin
                    queue_beat(sfr_pkg::ST_CSUM, cap_len[4:0], 4'd0, 8'h00, 1'b1);
                end else if (cap_len == 8'h00) begin
                    queue_beat(sfr_pkg::ST_OK, 5'd0, 4'd0, 8'h00, 1'b1);
                end else begin
                    for (int i = 0; i < cap_len; i++) begin
                        queue_beat(sfr_pkg::ST_OK, cap_len[4:0], 4'(i), store[i],
                                   (i + 1 == cap_len));
                    end
                end
            end
        endcase
    endfunction

    task automatic send_byte(input t_stim s);
        int gap;
        int n0;
        gap = pick_pause(tx_calm);
        repeat (gap) begin
            @(negedge i_clk);
            rx.valid <= 1'b0;
        end
        @(negedge i_clk);
        rx.valid   <= 1'b1;
        rx.rx_byte <= s.data;
        do @(posedge i_clk); while (!rx.ready);
        items_taken++;
        n0 = due_beats.size();
        deframe(s.data);
        if (s.typed) begin
            while (due_beats.size() > n0) void'(due_beats.pop_back());
            due_beats.push_back(s.want);
        end
    endtask

    task automatic send_raw(input logic [7:0] b);
        send_byte({b, 1'b0, NO_BEAT});
    endtask

    task automatic send_frame();
        int kind;
        int r;
        int len;
        logic [7:0] sum;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            // broken header
            send_raw(sfr_pkg::HDR1);
            b = 8'($urandom_range(0, 255));
            if (b == sfr_pkg::HDR2) b = 8'h00;
            send_raw(b);
            return;
        end
        if (kind < 10) begin
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom_range(0, 255));
                if (b == sfr_pkg::HDR1) b = 8'h01;
                send_raw(b);
            end
            return;
        end
        if (kind < 14) begin
            // frame cut short, the next frame gets absorbed into it
            send_raw(sfr_pkg::HDR1);
            send_raw(sfr_pkg::HDR2);
            repeat ($urandom_range(1, 4)) send_raw(field_byte());
            return;
        end
        if ($urandom_range(0, 99) < 20) begin
            repeat ($urandom_range(1, 2)) send_raw(sfr_pkg::HDR1);
        end
        send_raw(sfr_pkg::HDR1);
        send_raw(sfr_pkg::HDR2);
        sum = sfr_pkg::HDR1 + sfr_pkg::HDR2;
        repeat (3) begin
            b = field_byte();
            sum += b;
            send_raw(b);
        end
        r = $urandom_range(0, 99);
        if (r < 12) len = 0;
        else if (r < 27) len = sfr_pkg::MAX_PAYLOAD;
        else if (r < 31) len = 255;
        else if (r < 37) len = $urandom_range(sfr_pkg::MAX_PAYLOAD + 1, 254);
        else len = $urandom_range(1, sfr_pkg::MAX_PAYLOAD - 1);
        b = 8'(len);
        sum += b;
        send_raw(b);
        if (len > sfr_pkg::MAX_PAYLOAD) return;
        repeat (len) begin
            b = field_byte();
            sum += b;
            send_raw(b);
        end
        b = -sum;
        if ($urandom_range(0, 99) < 15) b = b + 8'($urandom_range(1, 255));
        send_raw(b);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (sink_hold == 0) sink_hold = pick_pause(rx_calm);
            if (sink_hold > 0) begin
                res.ready <= 1'b0;
                sink_hold--;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            seen_beat = {res.status, res.src_addr, res.dst_addr, res.command, res.payload_len,
                         res.byte_index, res.payload_byte, res.last};
            if (due_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected beat: %s", beat_str(seen_beat));
                end
            end else begin
                due_beat = due_beats.pop_front();
                if (seen_beat !== due_beat) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("beat mismatch: expected %s", beat_str(due_beat));
                        $display("                    got %s", beat_str(seen_beat));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx.valid && rx.ready) || (res.valid && res.ready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("serial_frame_receiver verification failed");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    initial begin
        rx.valid   = 1'b0;
        rx.rx_byte = 8'h00;
        i_rst_n    = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIRECTED[k]) send_byte(DIRECTED[k]);
        while (items_taken < ITEM_TARGET) send_frame();
        @(negedge i_clk);
        rx.valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && due_beats.size() == 0) begin
            $display("serial_frame_receiver verification clean");
        end else begin
            $display("serial_frame_receiver verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
